### rtl/tnm_pkg.sv
// ----------------------------------------------------------------------------
// TDMA node membership table package
// Shared types, sizes and codes for the membership table block.
// ----------------------------------------------------------------------------
package tnm_pkg;

   localparam int MAX_NODES      = 16;
   localparam int BEACON_ENTRIES = 8;
   localparam int IDX_W          = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W          = $clog2(MAX_NODES + 1);

   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(MAX_NODES - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] BEACON_MAX  = CNT_W'(BEACON_ENTRIES);

   // Input modes.
   localparam logic [1:0] MODE_FRAME  = 2'd0;
   localparam logic [1:0] MODE_SWEEP  = 2'd1;
   localparam logic [1:0] MODE_BEACON = 2'd2;

   // Message types.
   localparam logic [1:0] MSG_JOIN  = 2'd0;
   localparam logic [1:0] MSG_OTHER = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_SWEEP  = 2'd1;
   localparam logic [1:0] KIND_HEADER = 2'd2;
   localparam logic [1:0] KIND_ENTRY  = 2'd3;

   // Frame actions.
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ADDED   = 3'd1;
   localparam logic [2:0] ACT_REFRESH = 3'd2;
   localparam logic [2:0] ACT_FULL    = 3'd3;
   localparam logic [2:0] ACT_DUP     = 3'd4;

   // Register indexes and reset values.
   localparam logic [1:0] REG_SELF_ID   = 2'd0;
   localparam logic [1:0] REG_BCAST_ID  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;
   localparam logic [15:0] SELF_ID_RST  = 16'd0;
   localparam logic [15:0] BCAST_ID_RST = 16'hFFFF;
   localparam logic [31:0] TIMEOUT_RST  = 32'd60000;

   // One table entry as it travels along the chain.
   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  slot;
      logic [31:0] seen;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic [1:0]       kind;
      logic             accepted;
      logic [2:0]       action;
      logic [3:0]       entry_index;
      logic [15:0]      node_addr;
      logic [7:0]       slot_number;
      logic [CNT_W-1:0] member_count;
      logic [7:0]       beacon_seq;
      logic [CNT_W-1:0] removed_count;
      logic             last;
   } result_type;

   // Control from the sequencer to the chain.
   typedef struct packed {
      logic      rotate;
      logic      write;
      entry_type wr_data;
   } chain_ctl_type;

endpackage

### rtl/tdma_node_membership_table_unit.sv
// ----------------------------------------------------------------------------
// TDMA node membership table
// Coordinator membership table: frame handling, stale sweep, beacon read-out.
// ----------------------------------------------------------------------------
// The table is a ring of 16 cells that rotates one entry per cycle past a
// head cell while the sequencer walks it, unless a beacon entry waits on an
// output stall; every table walk is a full revolution. A frame is accepted,
// walks one revolution for the lookup, one more when it adds or refreshes
// an entry, and then loads the result word. A refused add skips the write
// revolution, and a frame that is not addressed here or carries another
// message type goes straight to the load. A sweep walks one revolution per
// occupied entry, one more to land the last move, and then loads its result
// word; on an empty table it goes straight to the load. A beacon loads a
// header word and then walks a revolution for its entries, stretched by any
// output stall. A new word is taken only while the sequencer is idle; a
// finished result word may still wait at the output.
// ----------------------------------------------------------------------------
module tdma_node_membership_table_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [15:0]               req_dst_id,
   input  logic [15:0]               req_src_id,
   input  logic [1:0]                req_msg_type,
   input  logic [31:0]               req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic                      rsp_accepted,
   output logic [2:0]                rsp_action,
   output logic [3:0]                rsp_entry_index,
   output logic [15:0]               rsp_node_addr,
   output logic [7:0]                rsp_slot_number,
   output logic [tnm_pkg::CNT_W-1:0] rsp_member_count,
   output logic [7:0]                rsp_beacon_seq,
   output logic [tnm_pkg::CNT_W-1:0] rsp_removed_count,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import tnm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOOK  = 8'b0000_0010,
      ST_WRITE = 8'b0000_0100,
      ST_SWEEP = 8'b0000_1000,
      ST_FLUSH = 8'b0001_0000,
      ST_EMIT  = 8'b0010_0000,
      ST_BHDR  = 8'b0100_0000,
      ST_BEAC  = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      self_id_ff, self_id_in;
   logic [15:0]      bcast_id_ff, bcast_id_in;
   logic [31:0]      timeout_ff, timeout_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [7:0]       seq_ff, seq_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      src_ff, src_in;
   logic [1:0]       type_ff, type_in;
   logic [31:0]      now_ff, now_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   entry_type        fent_ff, fent_in;
   logic [IDX_W-1:0] sw_i_ff, sw_i_in;
   logic             stale_ff, stale_in;
   entry_type        top_ff, top_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   entry_type        wr_data_ff, wr_data_in;
   result_type       res_ff, res_in;
   result_type       out_ff, out_in;
   logic             rsp_valid_ff, rsp_valid_in;

   chain_ctl_type    ctl;
   entry_type        head;
   logic             can_load;
   logic             load_en;
   result_type       load_res;
   logic             in_fire;
   logic             last_cnt;
   logic [IDX_W-1:0] cnt_next;
   logic             cnt_live;
   logic             hit_now;
   logic             f_any;
   logic [IDX_W-1:0] f_idx;
   entry_type        f_ent;
   logic [IDX_W-1:0] top_idx;
   logic             s_fin;
   entry_type        t_fin;
   logic [31:0]      age;
   logic [CNT_W-1:0] beacon_n;
   logic             to_me;

   // Ring of table entries.
   tnm_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   // Handshakes and shared decodes.
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign in_fire   = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign last_cnt  = (cnt_ff == LAST_IDX);
   assign cnt_next  = last_cnt ? '0 : cnt_ff + 1'b1;
   assign cnt_live  = ({1'b0, cnt_ff} < total_ff);
   assign to_me     = (req_dst_id == self_id_ff) || (req_dst_id == bcast_id_ff);
   assign beacon_n  = (total_ff < BEACON_MAX) ? total_ff : BEACON_MAX;

   // Lookup: first live entry that matches the source address.
   assign hit_now = cnt_live && (head.addr == src_ff) && !found_ff;
   assign f_any   = found_ff || hit_now;
   assign f_idx   = found_ff ? fidx_ff : cnt_ff;
   assign f_ent   = found_ff ? fent_ff : head;

   // Sweep: age of the entry at the head and the current top entry.
   assign age     = now_ff - head.seen;
   assign top_idx = IDX_W'(total_ff - 1'b1);
   assign s_fin   = (cnt_ff == sw_i_ff) ? (age > timeout_ff) : stale_ff;
   assign t_fin   = (cnt_ff == top_idx) ? head : top_ff;

   // Chain control: writes land while the target passes the head.
   always_comb begin
      ctl.wr_data = wr_data_ff;
      ctl.write   = 1'b0;
      ctl.rotate  = 1'b0;
      case (state_ff)
         ST_LOOK: begin
            ctl.rotate = 1'b1;
         end
         ST_WRITE, ST_SWEEP, ST_FLUSH: begin
            ctl.rotate = 1'b1;
            ctl.write  = wr_pend_ff && (cnt_ff == wr_idx_ff);
         end
         ST_BEAC: begin
            ctl.rotate = ({1'b0, cnt_ff} < beacon_n) ? can_load : 1'b1;
         end
         default: begin
            ctl.rotate = 1'b0;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      self_id_in  = self_id_ff;
      bcast_id_in = bcast_id_ff;
      timeout_in  = timeout_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SELF_ID:  self_id_in  = csr_data[15:0];
            REG_BCAST_ID: bcast_id_in = csr_data[15:0];
            REG_TIMEOUT:  timeout_in  = csr_data;
            default:      self_id_in  = self_id_ff;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      seq_in     = seq_ff;
      cnt_in     = cnt_ff;
      src_in     = src_ff;
      type_in    = type_ff;
      now_in     = now_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      fent_in    = fent_ff;
      sw_i_in    = sw_i_ff;
      stale_in   = stale_ff;
      top_in     = top_ff;
      removed_in = removed_ff;
      wr_pend_in = wr_pend_ff;
      wr_idx_in  = wr_idx_ff;
      wr_data_in = wr_data_ff;
      res_in     = res_ff;
      load_en    = 1'b0;
      load_res   = '0;
      if (ctl.rotate) begin
         cnt_in = cnt_next;
      end
      case (state_ff)
         ST_IDLE: begin
            if (in_fire) begin
               src_in   = req_src_id;
               type_in  = req_msg_type;
               now_in   = req_now_ms;
               cnt_in   = '0;
               found_in = 1'b0;
               res_in   = '0;
               res_in.member_count = total_ff;
               res_in.last         = 1'b1;
               case (req_mode)
                  MODE_FRAME: begin
                     res_in.accepted = to_me;
                     if (to_me && (req_msg_type != MSG_OTHER)) begin
                        state_in = ST_LOOK;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  MODE_SWEEP: begin
                     res_in.kind = KIND_SWEEP;
                     removed_in  = '0;
                     wr_pend_in  = 1'b0;
                     sw_i_in     = IDX_W'(total_ff - 1'b1);
                     state_in    = (total_ff == '0) ? ST_EMIT : ST_SWEEP;
                  end
                  MODE_BEACON: begin
                     state_in = ST_BHDR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (hit_now) begin
               found_in = 1'b1;
               fidx_in  = cnt_ff;
               fent_in  = head;
            end
            if (last_cnt) begin
               res_in.node_addr = src_ff;
               if (f_any) begin
                  res_in.entry_index = 4'(f_idx);
                  res_in.slot_number = f_ent.slot;
                  if (type_ff == MSG_JOIN) begin
                     res_in.action = ACT_DUP;
                     state_in      = ST_EMIT;
                  end else begin
                     res_in.action = ACT_REFRESH;
                     wr_pend_in    = 1'b1;
                     wr_idx_in     = f_idx;
                     wr_data_in    = '{addr: f_ent.addr, slot: f_ent.slot, seen: now_ff};
                     state_in      = ST_WRITE;
                  end
               end else if (total_ff >= FULL_COUNT) begin
                  res_in.action = ACT_FULL;
                  state_in      = ST_EMIT;
               end else begin
                  res_in.action       = ACT_ADDED;
                  res_in.entry_index  = 4'(total_ff);
                  res_in.slot_number  = 8'(total_ff) + 8'd2;
                  res_in.member_count = total_ff + 1'b1;
                  total_in            = total_ff + 1'b1;
                  wr_pend_in          = 1'b1;
                  wr_idx_in           = IDX_W'(total_ff);
                  wr_data_in          = '{addr: src_ff, slot: 8'(total_ff) + 8'd2,
                                          seen: now_ff};
                  state_in            = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (last_cnt) begin
               wr_pend_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_SWEEP: begin
            // One revolution per index, from the top down.
            if (cnt_ff == sw_i_ff) begin
               stale_in = age > timeout_ff;
            end
            if (cnt_ff == top_idx) begin
               top_in = head;
            end
            if (last_cnt) begin
               wr_pend_in = s_fin;
               if (s_fin) begin
                  wr_idx_in  = sw_i_ff;
                  wr_data_in = t_fin;
                  total_in   = total_ff - 1'b1;
                  removed_in = removed_ff + 1'b1;
               end
               if (sw_i_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  sw_i_in = sw_i_ff - 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (last_cnt) begin
               wr_pend_in           = 1'b0;
               res_in.removed_count = removed_ff;
               res_in.member_count  = total_ff;
               state_in             = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               load_en  = 1'b1;
               load_res = res_ff;
               state_in = ST_IDLE;
            end
         end
         ST_BHDR: begin
            if (can_load) begin
               load_en               = 1'b1;
               load_res.kind         = KIND_HEADER;
               load_res.member_count = total_ff;
               load_res.beacon_seq   = seq_ff;
               load_res.last         = (beacon_n == '0);
               seq_in                = seq_ff + 8'd1;
               cnt_in                = '0;
               state_in              = (beacon_n == '0) ? ST_IDLE : ST_BEAC;
            end
         end
         ST_BEAC: begin
            if (({1'b0, cnt_ff} < beacon_n) && can_load) begin
               load_en               = 1'b1;
               load_res.kind         = KIND_ENTRY;
               load_res.entry_index  = 4'(cnt_ff);
               load_res.node_addr    = head.addr;
               load_res.slot_number  = head.slot;
               load_res.member_count = total_ff;
               load_res.last         = ({1'b0, cnt_ff} == beacon_n - 1'b1);
            end
            if (ctl.rotate && last_cnt) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      out_in       = load_en ? load_res : out_ff;
      rsp_valid_in = load_en ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         self_id_ff   <= SELF_ID_RST;
         bcast_id_ff  <= BCAST_ID_RST;
         timeout_ff   <= TIMEOUT_RST;
         total_ff     <= '0;
         seq_ff       <= '0;
         cnt_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         self_id_ff   <= self_id_in;
         bcast_id_ff  <= bcast_id_in;
         timeout_ff   <= timeout_in;
         total_ff     <= total_in;
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      type_ff    <= type_in;
      now_ff     <= now_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      fent_ff    <= fent_in;
      sw_i_ff    <= sw_i_in;
      stale_ff   <= stale_in;
      top_ff     <= top_in;
      removed_ff <= removed_in;
      wr_idx_ff  <= wr_idx_in;
      wr_data_ff <= wr_data_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_action        = out_ff.action;
   assign rsp_entry_index   = out_ff.entry_index;
   assign rsp_node_addr     = out_ff.node_addr;
   assign rsp_slot_number   = out_ff.slot_number;
   assign rsp_member_count  = out_ff.member_count;
   assign rsp_beacon_seq    = out_ff.beacon_seq;
   assign rsp_removed_count = out_ff.removed_count;
   assign rsp_last          = out_ff.last;

endmodule

### rtl/tnm_cell.sv
// ----------------------------------------------------------------------------
// Membership table cell
// Holds one table entry and takes its neighbor's entry when the row rotates.
// ----------------------------------------------------------------------------
module tnm_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  tnm_pkg::entry_type d,
   output tnm_pkg::entry_type q
);
   import tnm_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Take the neighbor's entry on a shift, hold otherwise.
   always_comb begin
      entry_in = shift_en ? d : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

### rtl/tnm_chain.sv
// ----------------------------------------------------------------------------
// Membership table ring
// A ring of cells; the head cell is visible to the sequencer and can be
// replaced as it wraps around to the tail.
// ----------------------------------------------------------------------------
module tnm_chain (
   input  logic                   clock,
   input  tnm_pkg::chain_ctl_type ctl,
   output tnm_pkg::entry_type     head
);
   import tnm_pkg::*;

   entry_type q [MAX_NODES];
   entry_type d [MAX_NODES];
   entry_type head_eff;

   // The head as seen this cycle, with a pending write applied.
   always_comb begin
      head_eff = ctl.write ? ctl.wr_data : q[0];
   end

   // Each cell takes its upper neighbor; the tail takes the head.
   always_comb begin
      for (int k = 0; k < MAX_NODES - 1; k++) begin
         d[k] = q[k+1];
      end
      d[MAX_NODES-1] = head_eff;
   end

   for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
      tnm_cell u_cell (
         .clock    (clock),
         .shift_en (ctl.rotate),
         .d        (d[k]),
         .q        (q[k])
      );
   end

   assign head = head_eff;

endmodule

### rtl/tnm_checker.sv
// ----------------------------------------------------------------------------
// Membership table port checker
// Watches the result port of the membership table over time.
// ----------------------------------------------------------------------------
module tnm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_kind,
   input logic                      rsp_accepted,
   input logic [2:0]                rsp_action,
   input logic [tnm_pkg::CNT_W-1:0] rsp_member_count,
   input logic                      rsp_last
);
   import tnm_pkg::*;

   // A stalled word stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Frame and sweep results are single words.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FRAME || rsp_kind == KIND_SWEEP) |-> rsp_last)
      else $error("frame or sweep result not marked last");

   // A frame that was not taken carries no action.
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FRAME && !rsp_accepted |-> rsp_action == ACT_NONE)
      else $error("action on a rejected frame");

   // The table never holds more than its capacity.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_member_count <= FULL_COUNT)
      else $error("member count above capacity");

endmodule

bind tdma_node_membership_table_unit tnm_checker u_tnm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_accepted     (rsp_accepted),
   .rsp_action       (rsp_action),
   .rsp_member_count (rsp_member_count),
   .rsp_last         (rsp_last)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Membership table testbench
// Drives received frames, stale sweeps and beacon read-outs into the table
// unit under random handshake idling. Every result word is checked against a
// predictor of the table that runs alongside the block.
// ----------------------------------------------------------------------------
module tb;
   import tnm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 600;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = '0;
   logic [15:0]        req_dst_id = '0;
   logic [15:0]        req_src_id = '0;
   logic [1:0]         req_msg_type = '0;
   logic [31:0]        req_now_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic               rsp_accepted;
   logic [2:0]         rsp_action;
   logic [3:0]         rsp_entry_index;
   logic [15:0]        rsp_node_addr;
   logic [7:0]         rsp_slot_number;
   logic [CNT_W-1:0]   rsp_member_count;
   logic [7:0]         rsp_beacon_seq;
   logic [CNT_W-1:0]   rsp_removed_count;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   tdma_node_membership_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_dst_id(req_dst_id), .req_src_id(req_src_id),
      .req_msg_type(req_msg_type), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_accepted(rsp_accepted), .rsp_action(rsp_action),
      .rsp_entry_index(rsp_entry_index), .rsp_node_addr(rsp_node_addr),
      .rsp_slot_number(rsp_slot_number), .rsp_member_count(rsp_member_count),
      .rsp_beacon_seq(rsp_beacon_seq), .rsp_removed_count(rsp_removed_count),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the table and its registers.
   logic [15:0] shd_self;
   logic [15:0] shd_bcast;
   logic [31:0] shd_timeout;
   logic [15:0] shd_addr [MAX_NODES];
   logic [7:0]  shd_slot [MAX_NODES];
   logic [31:0] shd_seen [MAX_NODES];
   int          shd_total;
   logic [7:0]  shd_seq;

   result_type  pending_words [$];
   int          err_count = 0;
   int          word_count = 0;
   int          item_count = 0;
   int          sweep_removed = 0;
   int          full_refusals = 0;
   int          snd_idle = 0;
   int          rcv_idle = 0;
   int          quiet_cycles = 0;

   // Queue one expected word; member count is the table size at this point.
   function automatic result_type push_word(logic [1:0] kind, logic acc,
         logic [2:0] act, int idx, logic [15:0] addr, logic [7:0] slot,
         logic [7:0] seq, int removed, logic last);
      result_type w;
      w = '0;
      w.kind = kind;
      w.accepted = acc;
      w.action = act;
      w.entry_index = 4'(idx);
      w.node_addr = addr;
      w.slot_number = slot;
      w.member_count = CNT_W'(shd_total);
      w.beacon_seq = seq;
      w.removed_count = CNT_W'(removed);
      w.last = last;
      pending_words.push_back(w);
      return w;
   endfunction

   function automatic int find_node(logic [15:0] addr);
      for (int i = 0; i < shd_total; i++)
         if (shd_addr[i] == addr) return i;
      return -1;
   endfunction

   // Join path: refuse duplicates first, then a full table, else append.
   function automatic result_type admit_node(logic [15:0] src, logic [31:0] now);
      int hit;
      int idx;
      hit = find_node(src);
      if (hit >= 0)
         return push_word(KIND_FRAME, 1'b1, ACT_DUP, hit, src, shd_slot[hit], 0, 0, 1'b1);
      if (shd_total >= MAX_NODES) begin
         full_refusals++;
         return push_word(KIND_FRAME, 1'b1, ACT_FULL, 0, src, 8'd0, 0, 0, 1'b1);
      end
      idx = shd_total;
      shd_total++;
      shd_addr[idx] = src;
      shd_slot[idx] = 8'(shd_total + 1);
      shd_seen[idx] = now;
      return push_word(KIND_FRAME, 1'b1, ACT_ADDED, idx, src, shd_slot[idx], 0, 0, 1'b1);
   endfunction

   // Works out the words an accepted item causes; returns the first one.
   function automatic result_type predict_table(logic [1:0] mode, logic [15:0] dst,
         logic [15:0] src, logic [1:0] msg, logic [31:0] now);
      result_type first;
      int hit;
      int removed;
      int n;
      first = '0;
      if (mode == MODE_FRAME) begin
         if (dst != shd_self && dst != shd_bcast)
            first = push_word(KIND_FRAME, 1'b0, ACT_NONE, 0, 16'd0, 8'd0, 0, 0, 1'b1);
         else if (msg == MSG_JOIN)
            first = admit_node(src, now);
         else if (msg == MSG_OTHER)
            first = push_word(KIND_FRAME, 1'b1, ACT_NONE, 0, 16'd0, 8'd0, 0, 0, 1'b1);
         else begin
            hit = find_node(src);
            if (hit >= 0) begin
               shd_seen[hit] = now;
               first = push_word(KIND_FRAME, 1'b1, ACT_REFRESH, hit, src,
                                 shd_slot[hit], 0, 0, 1'b1);
            end else
               first = admit_node(src, now);
         end
      end else if (mode == MODE_SWEEP) begin
         removed = 0;
         for (int i = shd_total - 1; i >= 0; i--) begin
            if (i < shd_total && (now - shd_seen[i]) > shd_timeout) begin
               shd_addr[i] = shd_addr[shd_total-1];
               shd_slot[i] = shd_slot[shd_total-1];
               shd_seen[i] = shd_seen[shd_total-1];
               shd_total--;
               removed++;
            end
         end
         sweep_removed += removed;
         first = push_word(KIND_SWEEP, 1'b0, ACT_NONE, 0, 16'd0, 8'd0, 0, removed, 1'b1);
      end else if (mode == MODE_BEACON) begin
         n = (shd_total < BEACON_ENTRIES) ? shd_total : BEACON_ENTRIES;
         first = push_word(KIND_HEADER, 1'b0, ACT_NONE, 0, 16'd0, 8'd0, shd_seq, 0,
                           n == 0);
         shd_seq++;
         for (int i = 0; i < n; i++)
            void'(push_word(KIND_ENTRY, 1'b0, ACT_NONE, i, shd_addr[i], shd_slot[i],
                            0, 0, i + 1 == n));
      end
      return first;
   endfunction

   // Result checker: every word must match the oldest expectation.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_accepted, rsp_action, rsp_entry_index, rsp_node_addr,
                 rsp_slot_number, rsp_member_count, rsp_beacon_seq, rsp_removed_count,
                 rsp_last};
         word_count++;
         if (pending_words.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("Unexpected result word %p", got);
         end else begin
            want = pending_words.pop_front();
            if (got != want) begin
               err_count++;
               if (err_count <= 10)
                  $display("Result mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Receiver stalls at random.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rcv_idle);

   // Watchdog on cycles in which no channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", pending_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Sends one item, idling first at random; valid stays high until accepted.
   task automatic send_item(logic [1:0] mode, logic [15:0] dst, logic [15:0] src,
         logic [1:0] msg, logic [31:0] now, output result_type first);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_mode <= mode;
      req_dst_id <= dst;
      req_src_id <= src;
      req_msg_type <= msg;
      req_now_ms <= now;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      first = predict_table(mode, dst, src, msg, now);
      if (mode != 2'd3) item_count++;
   endtask

   // Waits for every expected word, then lets the block settle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SELF_ID:  shd_self = data[15:0];
         REG_BCAST_ID: shd_bcast = data[15:0];
         REG_TIMEOUT:  shd_timeout = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Directed rows; a typed action is checked only where chk is set.
   typedef struct {
      logic [1:0]  mode;
      logic [15:0] dst;
      logic [15:0] src;
      logic [1:0]  msg;
      logic [31:0] now;
      logic        chk;
      logic        acc;
      logic [2:0]  act;
   } row_type;

   localparam int NROWS = 14;
   row_type rows [NROWS] = '{
      '{MODE_BEACON, 16'h0000, 16'h0000, 2'd0, 32'd0,          1'b1, 1'b0, ACT_NONE},
      '{MODE_FRAME,  16'h1234, 16'h0001, 2'd0, 32'd0,          1'b1, 1'b0, ACT_NONE},
      '{MODE_FRAME,  16'h0000, 16'h0000, 2'd0, 32'd0,          1'b1, 1'b1, ACT_ADDED},
      '{MODE_FRAME,  16'hFFFF, 16'h0000, 2'd0, 32'd5,          1'b1, 1'b1, ACT_DUP},
      '{MODE_FRAME,  16'hFFFF, 16'h0000, 2'd1, 32'd10,         1'b1, 1'b1, ACT_REFRESH},
      '{MODE_FRAME,  16'h0000, 16'hFFFF, 2'd2, 32'hFFFF_FFFF,  1'b1, 1'b1, ACT_ADDED},
      '{MODE_FRAME,  16'h0000, 16'hFFFF, 2'd2, 32'hFFFF_FFF0,  1'b1, 1'b1, ACT_REFRESH},
      '{MODE_FRAME,  16'hFFFF, 16'h5555, 2'd3, 32'd0,          1'b1, 1'b1, ACT_NONE},
      '{2'd3,        16'hFFFF, 16'hAAAA, 2'd0, 32'hAAAA_AAAA,  1'b0, 1'b0, ACT_NONE},
      '{MODE_SWEEP,  16'h0000, 16'h0000, 2'd0, 32'd60010,      1'b0, 1'b0, ACT_NONE},
      '{MODE_SWEEP,  16'h0000, 16'h0000, 2'd0, 32'd60011,      1'b0, 1'b0, ACT_NONE},
      '{MODE_FRAME,  16'h0000, 16'hAAAA, 2'd1, 32'h5555_5555,  1'b1, 1'b1, ACT_ADDED},
      '{MODE_BEACON, 16'h0000, 16'h0000, 2'd0, 32'd0,          1'b0, 1'b0, ACT_NONE},
      '{MODE_SWEEP,  16'h0000, 16'h0000, 2'd0, 32'h0000_0000,  1'b0, 1'b0, ACT_NONE}
   };

   // Random stimulus: frames mostly addressed here from a small address pool.
   task automatic random_items(int count);
      result_type first;
      logic [1:0]  mode;
      logic [15:0] dst;
      logic [15:0] src;
      logic [31:0] now;
      int          pick;
      int          sent;
      sent = 0;
      now = $urandom;
      while (sent < count) begin
         pick = $urandom_range(99);
         mode = (pick < 70) ? MODE_FRAME : (pick < 82) ? MODE_SWEEP :
                (pick < 96) ? MODE_BEACON : 2'd3;
         pick = $urandom_range(9);
         dst = (pick < 4) ? shd_self : (pick < 8) ? shd_bcast : 16'($urandom);
         src = ($urandom_range(9) < 8) ? 16'($urandom_range(23) * 16'h0A53) :
               16'($urandom);
         if ($urandom_range(19) == 0) now = $urandom;
         else now += $urandom_range(30000);
         send_item(mode, dst, src, 2'($urandom_range(3)), now, first);
         if (mode != 2'd3) sent++;
         // Now and then hold off until the table has answered everything.
         if ($urandom_range(49) == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_words.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      result_type first;
      shd_self = SELF_ID_RST;
      shd_bcast = BCAST_ID_RST;
      shd_timeout = TIMEOUT_RST;
      shd_total = 0;
      shd_seq = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings.
      for (int r = 0; r < NROWS; r++) begin
         send_item(rows[r].mode, rows[r].dst, rows[r].src, rows[r].msg, rows[r].now,
                   first);
         if (rows[r].chk && (first.accepted != rows[r].acc || first.action != rows[r].act))
         begin
            err_count++;
            if (err_count <= 10)
               $display("Row %0d: expected accepted %0d action %0d, predicted %0d %0d",
                        r, rows[r].acc, rows[r].act, first.accepted, first.action);
         end
      end
      // Fill the table past full, then read out and sweep it across the wrap.
      for (int k = 0; k < MAX_NODES + 1; k++)
         send_item(MODE_FRAME, 16'hFFFF, 16'(16'h0100 + k), MSG_JOIN, 32'hFFFF_FF00, first);
      send_item(MODE_BEACON, 16'h0000, 16'h0000, 2'd0, 32'd0, first);
      send_item(MODE_SWEEP, 16'h0000, 16'h0000, 2'd0, 32'd59000, first);
      send_item(MODE_SWEEP, 16'h0000, 16'h0000, 2'd0, 32'd90000, first);

      // Random phases, each under its own register setting, in pairs sharing an idle profile.
      for (int ph = 0; ph < 6; ph++) begin
         drain_results();
         snd_idle = (ph < 2) ? 23 : (ph < 4) ? 80 : 0;
         rcv_idle = (ph < 2) ? 80 : (ph < 4) ? 23 : 0;
         case (ph)
            0: begin
               write_reg(REG_SELF_ID, 32'h0000_FFFF);
               write_reg(REG_BCAST_ID, 32'h0000_0000);
               write_reg(REG_TIMEOUT, 32'h0000_0000);
            end
            1: write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
            default: begin
               write_reg(REG_SELF_ID, $urandom);
               write_reg(REG_BCAST_ID, $urandom);
               write_reg(REG_TIMEOUT, $urandom_range(200000));
            end
         endcase
         random_items(70);
      end

      drain_results();
      $display("Covered %0d items and %0d result words: %0d nodes swept out,",
               item_count, word_count, sweep_removed);
      $display("%0d adds refused on a full table, six register settings.", full_refusals);
      if (err_count == 0 && pending_words.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
rtl/tnm_pkg.sv
rtl/tnm_cell.sv
rtl/tnm_chain.sv
rtl/tdma_node_membership_table_unit.sv
rtl/tnm_checker.sv
sim/tb.sv
